[hw/rtl/obb2d_pkg.sv]
// Shared constants, types and fixed-point helpers for the oriented box overlap test.
// No dependencies; the trig, box, lane and top-level files import this package.
package obb2d_pkg;

    localparam int TRIG_LAT    = 13;
    localparam int BOX_LAT     = 2;
    localparam int LANE_LAT    = 4;
    localparam int MERGE_LAT   = 1;
    localparam int NUM_LANES   = 4;
    localparam int NUM_CORNERS = 4;

    localparam logic [31:0] PIQ30  = 32'd3373259426;
    localparam logic [30:0] ONEQ30 = 31'h4000_0000;
    localparam logic [30:0] EIGHTH = 31'h2000_0000;

    typedef logic [29:0] t_q30;

    // Exact floor division of a value below 2^30 by a constant D:
    // (v * ceil(2^S / D)) >> S with S = 30 + clog2(D).
    localparam int unsigned SH3  = 33;
    localparam int unsigned SH4  = 35;
    localparam int unsigned SH5  = 37;
    localparam int unsigned SH6  = 40;
    localparam int unsigned SH7  = 43;
    localparam int unsigned SH8  = 46;
    localparam int unsigned SH9  = 49;
    localparam int unsigned SH10 = 52;

    localparam logic [63:0] MW3  = ((64'd1 << SH3)  + 64'd5)       / 64'd6;
    localparam logic [63:0] MW4  = ((64'd1 << SH4)  + 64'd23)      / 64'd24;
    localparam logic [63:0] MW5  = ((64'd1 << SH5)  + 64'd119)     / 64'd120;
    localparam logic [63:0] MW6  = ((64'd1 << SH6)  + 64'd719)     / 64'd720;
    localparam logic [63:0] MW7  = ((64'd1 << SH7)  + 64'd5039)    / 64'd5040;
    localparam logic [63:0] MW8  = ((64'd1 << SH8)  + 64'd40319)   / 64'd40320;
    localparam logic [63:0] MW9  = ((64'd1 << SH9)  + 64'd362879)  / 64'd362880;
    localparam logic [63:0] MW10 = ((64'd1 << SH10) + 64'd3628799) / 64'd3628800;

    localparam logic [31:0] MUL3  = MW3[31:0];
    localparam logic [31:0] MUL4  = MW4[31:0];
    localparam logic [31:0] MUL5  = MW5[31:0];
    localparam logic [31:0] MUL6  = MW6[31:0];
    localparam logic [31:0] MUL7  = MW7[31:0];
    localparam logic [31:0] MUL8  = MW8[31:0];
    localparam logic [31:0] MUL9  = MW9[31:0];
    localparam logic [31:0] MUL10 = MW10[31:0];

    function automatic int frac_bits(input int cw);
        return ((60 - cw) < 30) ? (60 - cw) : 30;
    endfunction

    function automatic t_q30 mulq(input t_q30 a, input t_q30 b);
        logic [59:0] prod;
        prod = {30'd0, a} * {30'd0, b};
        return prod[59:30];
    endfunction

    function automatic t_q30 divc(input t_q30 v, input logic [31:0] m, input int unsigned sh);
        logic [61:0] prod;
        logic [61:0] shd;
        prod = {32'd0, v} * {30'd0, m};
        shd  = prod >> sh;
        return shd[29:0];
    endfunction

endpackage

[hw/rtl/obb2d_if.sv]
// Handshake channels of the box overlap test: box pairs in, overlap flags out.
// No dependencies.
interface obb2d_in_if #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_center_x;
    logic signed [COORD_WIDTH-1:0] a_center_y;
    logic        [COORD_WIDTH-2:0] a_half_w;
    logic        [COORD_WIDTH-2:0] a_half_h;
    logic        [ANGLE_WIDTH-1:0] a_angle;
    logic signed [COORD_WIDTH-1:0] b_center_x;
    logic signed [COORD_WIDTH-1:0] b_center_y;
    logic        [COORD_WIDTH-2:0] b_half_w;
    logic        [COORD_WIDTH-2:0] b_half_h;
    logic        [ANGLE_WIDTH-1:0] b_angle;

    modport source (
        output valid, a_center_x, a_center_y, a_half_w, a_half_h, a_angle,
               b_center_x, b_center_y, b_half_w, b_half_h, b_angle,
        input  ready
    );
    modport sink (
        input  valid, a_center_x, a_center_y, a_half_w, a_half_h, a_angle,
               b_center_x, b_center_y, b_half_w, b_half_h, b_angle,
        output ready
    );
endinterface

interface obb2d_out_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink (input valid, overlap, output ready);
endinterface

[hw/rtl/obb2d_trig.sv]
// Pipelined sine and cosine of a binary angle by a fixed-point Taylor series.
// Depends on obb2d_pkg; one result per cycle while i_en is high.
module obb2d_trig
    import obb2d_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16,
    parameter int FRAC        = 28
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [ANGLE_WIDTH-1:0] i_angle,
    output logic signed [FRAC+1:0] o_sin,
    output logic signed [FRAC+1:0] o_cos
);

    typedef enum logic [1:0] {Q_FIRST, Q_SECOND, Q_THIRD, Q_FOURTH} t_quad;

    typedef struct packed {
        t_quad            quad;
        logic             fold;
        logic [10:1][29:0] pw;
    } t_pw;

    typedef struct packed {
        t_quad quad;
        logic  fold;
        t_q30  p1;
        t_q30  h2;
        t_q30  q3;
        t_q30  q4;
        t_q30  q5;
        t_q30  q6;
        t_q30  q7;
        t_q30  q8;
        t_q30  q9;
        t_q30  q10;
    } t_term;

    typedef struct packed {
        t_quad       quad;
        logic        fold;
        logic [30:0] sm;
        logic [30:0] cm;
    } t_mag;

    localparam int          SH  = 30 - FRAC;
    localparam logic [31:0] RND = (SH == 0) ? 32'd0 : (32'd1 << (SH - 1));

    t_pw   r_pw [1:10];
    t_pw   n_pw;
    t_pw   n_shift [2:10];
    t_term r_term;
    t_term n_term;
    t_mag  r_mag;
    t_mag  n_mag;
    logic signed [FRAC+1:0] n_sin;
    logic signed [FRAC+1:0] n_cos;

    always_comb begin
        logic [31:0] t_full;
        logic [30:0] rf;
        logic [61:0] px;
        t_full       = 32'(i_angle) << (32 - ANGLE_WIDTH);
        n_pw         = '0;
        n_pw.quad    = t_quad'(t_full[31:30]);
        n_pw.fold    = {1'b0, t_full[29:0]} > EIGHTH;
        rf           = n_pw.fold ? (ONEQ30 - {1'b0, t_full[29:0]}) : {1'b0, t_full[29:0]};
        px           = {31'd0, rf} * {30'd0, PIQ30};
        n_pw.pw[1]   = px[60:31];
    end

    always_comb begin
        for (int i = 2; i <= 10; i++) begin
            n_shift[i]       = r_pw[i-1];
            n_shift[i].pw[i] = mulq(r_pw[i-1].pw[i-1], r_pw[i-1].pw[1]);
        end
    end

    always_comb begin
        n_term.quad = r_pw[10].quad;
        n_term.fold = r_pw[10].fold;
        n_term.p1   = r_pw[10].pw[1];
        n_term.h2   = r_pw[10].pw[2] >> 1;
        n_term.q3   = divc(r_pw[10].pw[3], MUL3, SH3);
        n_term.q4   = divc(r_pw[10].pw[4], MUL4, SH4);
        n_term.q5   = divc(r_pw[10].pw[5], MUL5, SH5);
        n_term.q6   = divc(r_pw[10].pw[6], MUL6, SH6);
        n_term.q7   = divc(r_pw[10].pw[7], MUL7, SH7);
        n_term.q8   = divc(r_pw[10].pw[8], MUL8, SH8);
        n_term.q9   = divc(r_pw[10].pw[9], MUL9, SH9);
        n_term.q10  = divc(r_pw[10].pw[10], MUL10, SH10);
    end

    always_comb begin
        logic signed [32:0] sv;
        logic signed [32:0] cv;
        sv = $signed({3'b0, r_term.p1}) - $signed({3'b0, r_term.q3})
           + $signed({3'b0, r_term.q5}) - $signed({3'b0, r_term.q7})
           + $signed({3'b0, r_term.q9});
        cv = $signed({2'b0, ONEQ30}) - $signed({3'b0, r_term.h2})
           + $signed({3'b0, r_term.q4}) - $signed({3'b0, r_term.q6})
           + $signed({3'b0, r_term.q8}) - $signed({3'b0, r_term.q10});
        n_mag.quad = r_term.quad;
        n_mag.fold = r_term.fold;
        if (sv < 0) begin
            n_mag.sm = '0;
        end else if (sv > $signed({2'b0, ONEQ30})) begin
            n_mag.sm = ONEQ30;
        end else begin
            n_mag.sm = sv[30:0];
        end
        if (cv < 0) begin
            n_mag.cm = '0;
        end else if (cv > $signed({2'b0, ONEQ30})) begin
            n_mag.cm = ONEQ30;
        end else begin
            n_mag.cm = cv[30:0];
        end
    end

    always_comb begin
        logic [30:0]            sm;
        logic [30:0]            cm;
        logic [31:0]            sr;
        logic [31:0]            cr;
        logic signed [FRAC+1:0] s0;
        logic signed [FRAC+1:0] c0;
        sm = r_mag.fold ? r_mag.cm : r_mag.sm;
        cm = r_mag.fold ? r_mag.sm : r_mag.cm;
        sr = ({1'b0, sm} + RND) >> SH;
        cr = ({1'b0, cm} + RND) >> SH;
        s0 = $signed({1'b0, sr[FRAC:0]});
        c0 = $signed({1'b0, cr[FRAC:0]});
        case (r_mag.quad)
            Q_FIRST: begin
                n_sin = s0;
                n_cos = c0;
            end
            Q_SECOND: begin
                n_sin = c0;
                n_cos = -s0;
            end
            Q_THIRD: begin
                n_sin = -s0;
                n_cos = -c0;
            end
            default: begin
                n_sin = -c0;
                n_cos = s0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pw[1] <= n_pw;
            for (int i = 2; i <= 10; i++) begin
                r_pw[i] <= n_shift[i];
            end
            r_term <= n_term;
            r_mag  <= n_mag;
            o_sin  <= n_sin;
            o_cos  <= n_cos;
        end
    end

endmodule

[hw/rtl/obb2d_box.sv]
// Corner generator: rotates the half extents of one box and adds its center.
// Depends on obb2d_pkg; two register stages.
module obb2d_box
    import obb2d_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC        = 28
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic        [COORD_WIDTH-2:0] i_hw,
    input  logic        [COORD_WIDTH-2:0] i_hh,
    input  logic signed [FRAC+1:0]        i_sn,
    input  logic signed [FRAC+1:0]        i_cs,
    output logic signed [COORD_WIDTH+1:0] o_x [NUM_CORNERS],
    output logic signed [COORD_WIDTH+1:0] o_y [NUM_CORNERS]
);

    localparam int PRW = COORD_WIDTH + FRAC + 2;
    localparam int SW  = PRW + 1;

    logic signed [PRW-1:0]         r_hwc;
    logic signed [PRW-1:0]         r_hhs;
    logic signed [PRW-1:0]         r_hws;
    logic signed [PRW-1:0]         r_hhc;
    logic signed [COORD_WIDTH-1:0] r_cx;
    logic signed [COORD_WIDTH-1:0] r_cy;
    logic signed [COORD_WIDTH+1:0] n_x [NUM_CORNERS];
    logic signed [COORD_WIDTH+1:0] n_y [NUM_CORNERS];

    always_comb begin
        logic signed [SW-1:0] hwc;
        logic signed [SW-1:0] hhs;
        logic signed [SW-1:0] hws;
        logic signed [SW-1:0] hhc;
        logic signed [SW-1:0] ox;
        logic signed [SW-1:0] oy;
        hwc = SW'(r_hwc);
        hhs = SW'(r_hhs);
        hws = SW'(r_hws);
        hhc = SW'(r_hhc);
        for (int k = 0; k < NUM_CORNERS; k++) begin
            ox = ((k % 2 == 1) ? hwc : -hwc) - ((k / 2 == 1) ? hhs : -hhs);
            oy = ((k % 2 == 1) ? hws : -hws) + ((k / 2 == 1) ? hhc : -hhc);
            ox = ox >>> FRAC;
            oy = oy >>> FRAC;
            n_x[k] = (COORD_WIDTH + 2)'(r_cx) + ox[COORD_WIDTH+1:0];
            n_y[k] = (COORD_WIDTH + 2)'(r_cy) + oy[COORD_WIDTH+1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hwc <= $signed({1'b0, i_hw}) * i_cs;
            r_hhs <= $signed({1'b0, i_hh}) * i_sn;
            r_hws <= $signed({1'b0, i_hw}) * i_sn;
            r_hhc <= $signed({1'b0, i_hh}) * i_cs;
            r_cx  <= i_cx;
            r_cy  <= i_cy;
            o_x   <= n_x;
            o_y   <= n_y;
        end
    end

endmodule

[hw/rtl/obb2d_lane.sv]
// One axis lane: projects the eight corners, finds each box's interval and flags a gap.
// Depends on obb2d_pkg; four register stages.
module obb2d_lane
    import obb2d_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC        = 28
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH+1:0] i_ax [NUM_CORNERS],
    input  logic signed [COORD_WIDTH+1:0] i_ay [NUM_CORNERS],
    input  logic signed [COORD_WIDTH+1:0] i_bx [NUM_CORNERS],
    input  logic signed [COORD_WIDTH+1:0] i_by [NUM_CORNERS],
    input  logic signed [FRAC+1:0]        i_ux,
    input  logic signed [FRAC+1:0]        i_uy,
    output logic                          o_sep
);

    localparam int PPW = COORD_WIDTH + FRAC + 4;
    localparam int NP  = 2 * NUM_CORNERS;

    logic signed [PPW-1:0] r_px [NP];
    logic signed [PPW-1:0] r_py [NP];
    logic signed [PPW:0]   r_pr [NP];
    logic signed [PPW:0]   r_amin;
    logic signed [PPW:0]   r_amax;
    logic signed [PPW:0]   r_bmin;
    logic signed [PPW:0]   r_bmax;
    logic signed [PPW-1:0] n_px [NP];
    logic signed [PPW-1:0] n_py [NP];
    logic signed [PPW:0]   n_amin;
    logic signed [PPW:0]   n_amax;
    logic signed [PPW:0]   n_bmin;
    logic signed [PPW:0]   n_bmax;

    always_comb begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
            n_px[k]               = i_ax[k] * i_ux;
            n_py[k]               = i_ay[k] * i_uy;
            n_px[k + NUM_CORNERS] = i_bx[k] * i_ux;
            n_py[k + NUM_CORNERS] = i_by[k] * i_uy;
        end
    end

    always_comb begin
        logic signed [PPW:0] lo0;
        logic signed [PPW:0] lo1;
        logic signed [PPW:0] hi0;
        logic signed [PPW:0] hi1;
        lo0    = (r_pr[1] < r_pr[0]) ? r_pr[1] : r_pr[0];
        lo1    = (r_pr[3] < r_pr[2]) ? r_pr[3] : r_pr[2];
        hi0    = (r_pr[1] > r_pr[0]) ? r_pr[1] : r_pr[0];
        hi1    = (r_pr[3] > r_pr[2]) ? r_pr[3] : r_pr[2];
        n_amin = (lo1 < lo0) ? lo1 : lo0;
        n_amax = (hi1 > hi0) ? hi1 : hi0;
        lo0    = (r_pr[5] < r_pr[4]) ? r_pr[5] : r_pr[4];
        lo1    = (r_pr[7] < r_pr[6]) ? r_pr[7] : r_pr[6];
        hi0    = (r_pr[5] > r_pr[4]) ? r_pr[5] : r_pr[4];
        hi1    = (r_pr[7] > r_pr[6]) ? r_pr[7] : r_pr[6];
        n_bmin = (lo1 < lo0) ? lo1 : lo0;
        n_bmax = (hi1 > hi0) ? hi1 : hi0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= n_px;
            r_py <= n_py;
            for (int k = 0; k < NP; k++) begin
                r_pr[k] <= (PPW + 1)'(r_px[k]) + (PPW + 1)'(r_py[k]);
            end
            r_amin <= n_amin;
            r_amax <= n_amax;
            r_bmin <= n_bmin;
            r_bmax <= n_bmax;
            o_sep  <= (r_amax < r_bmin) || (r_bmax < r_amin);
        end
    end

endmodule

[hw/rtl/obb2d_sat_intersect.sv]
// Top level of the oriented box overlap test: trig units, corner generators, axis lanes.
// Depends on obb2d_pkg, obb2d_if, obb2d_trig, obb2d_box and obb2d_lane.
//
//   channel   dir   interface      carries
//   i_pair    in    obb2d_in_if    two boxes: centers, half extents, angles
//   o_res     out   obb2d_out_if   overlap flag, one per item
//
// One item is accepted per cycle unless a stalled output holds the pipeline; each result
// passes the sine/cosine units, corner generators, axis lanes, merge and output registers.
// Reset is synchronous and clears only the valid bits, the output valid among them.
// A stalled output holds the pipeline only when its last stage carries an item.
module obb2d_sat_intersect
    import obb2d_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obb2d_in_if.sink    i_pair,
    obb2d_out_if.source o_res
);

    localparam int FRAC     = frac_bits(COORD_WIDTH);
    localparam int CW2      = COORD_WIDTH + 2;
    localparam int PIPE_LAT = TRIG_LAT + BOX_LAT + LANE_LAT + MERGE_LAT;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic        [COORD_WIDTH-2:0] hw;
        logic        [COORD_WIDTH-2:0] hh;
    } t_geom;

    typedef struct packed {
        t_geom a;
        t_geom b;
    } t_pair;

    logic                   w_en;
    logic [PIPE_LAT-1:0]    r_v;
    t_pair                  r_gd [1:TRIG_LAT];
    t_pair                  n_gd;
    logic signed [FRAC+1:0] w_sa;
    logic signed [FRAC+1:0] w_ca;
    logic signed [FRAC+1:0] w_sb;
    logic signed [FRAC+1:0] w_cb;
    logic signed [FRAC+1:0] n_ux [NUM_LANES];
    logic signed [FRAC+1:0] n_uy [NUM_LANES];
    logic signed [FRAC+1:0] r_ux1 [NUM_LANES];
    logic signed [FRAC+1:0] r_uy1 [NUM_LANES];
    logic signed [FRAC+1:0] r_ux2 [NUM_LANES];
    logic signed [FRAC+1:0] r_uy2 [NUM_LANES];
    logic signed [CW2-1:0]  w_ax [NUM_CORNERS];
    logic signed [CW2-1:0]  w_ay [NUM_CORNERS];
    logic signed [CW2-1:0]  w_bx [NUM_CORNERS];
    logic signed [CW2-1:0]  w_by [NUM_CORNERS];
    logic [NUM_LANES-1:0]   w_sep;
    logic                   r_hit;
    logic                   r_out_valid;
    logic                   r_out_overlap;

    assign w_en           = !(r_v[PIPE_LAT-1] && r_out_valid && !o_res.ready);
    assign i_pair.ready   = w_en;
    assign o_res.valid    = r_out_valid;
    assign o_res.overlap  = r_out_overlap;

    assign n_gd.a.cx = i_pair.a_center_x;
    assign n_gd.a.cy = i_pair.a_center_y;
    assign n_gd.a.hw = i_pair.a_half_w;
    assign n_gd.a.hh = i_pair.a_half_h;
    assign n_gd.b.cx = i_pair.b_center_x;
    assign n_gd.b.cy = i_pair.b_center_y;
    assign n_gd.b.hw = i_pair.b_half_w;
    assign n_gd.b.hh = i_pair.b_half_h;

    obb2d_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .FRAC(FRAC)) u_trig_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_pair.a_angle),
        .o_sin   (w_sa),
        .o_cos   (w_ca)
    );

    obb2d_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .FRAC(FRAC)) u_trig_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_pair.b_angle),
        .o_sin   (w_sb),
        .o_cos   (w_cb)
    );

    obb2d_box #(.COORD_WIDTH(COORD_WIDTH), .FRAC(FRAC)) u_box_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cx  (r_gd[TRIG_LAT].a.cx),
        .i_cy  (r_gd[TRIG_LAT].a.cy),
        .i_hw  (r_gd[TRIG_LAT].a.hw),
        .i_hh  (r_gd[TRIG_LAT].a.hh),
        .i_sn  (w_sa),
        .i_cs  (w_ca),
        .o_x   (w_ax),
        .o_y   (w_ay)
    );

    obb2d_box #(.COORD_WIDTH(COORD_WIDTH), .FRAC(FRAC)) u_box_b (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cx  (r_gd[TRIG_LAT].b.cx),
        .i_cy  (r_gd[TRIG_LAT].b.cy),
        .i_hw  (r_gd[TRIG_LAT].b.hw),
        .i_hh  (r_gd[TRIG_LAT].b.hh),
        .i_sn  (w_sb),
        .i_cs  (w_cb),
        .o_x   (w_bx),
        .o_y   (w_by)
    );

    always_comb begin
        n_ux[0] = w_ca;
        n_uy[0] = w_sa;
        n_ux[1] = w_sa;
        n_uy[1] = -w_ca;
        n_ux[2] = w_cb;
        n_uy[2] = w_sb;
        n_ux[3] = w_sb;
        n_uy[3] = -w_cb;
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        obb2d_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC(FRAC)) u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ax  (w_ax),
            .i_ay  (w_ay),
            .i_bx  (w_bx),
            .i_by  (w_by),
            .i_ux  (r_ux2[g]),
            .i_uy  (r_uy2[g]),
            .o_sep (w_sep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gd[1] <= n_gd;
            for (int i = 2; i <= TRIG_LAT; i++) begin
                r_gd[i] <= r_gd[i-1];
            end
            r_ux1 <= n_ux;
            r_uy1 <= n_uy;
            r_ux2 <= r_ux1;
            r_uy2 <= r_uy1;
            r_hit <= ~|w_sep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_v <= {r_v[PIPE_LAT-2:0], i_pair.valid};
            end
            if (o_res.ready || !r_out_valid) begin
                r_out_valid <= r_v[PIPE_LAT-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res.ready || !r_out_valid) begin
            r_out_overlap <= r_hit;
        end
    end

endmodule

[hw/rtl/obb2d_chk.sv]
// Port-level checks for the oriented box overlap test, bound to its top level.
// Depends on obb2d_sat_intersect and its interface ports.
module obb2d_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_overlap
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_overlap))
        else $error("A waiting result item changed or vanished.");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("Input was refused while the output side was free.");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_out_valid)
        else $error("A result item appeared right after reset.");

    a_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |=> !$past(i_out_ready))
        else $error("An input item stalled although the output was taken.");

endmodule

bind obb2d_sat_intersect obb2d_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pair.valid),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_overlap   (o_res.overlap)
);
